>>> hw/rtl/rss_pkg.sv
package rss_pkg;

  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned MAX_ROWS  = 1024;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COL_W       = 10;
  localparam int unsigned ROW_W       = 10;
  localparam int unsigned REM_W       = 9;
  localparam int unsigned CLIP_L_W    = 10;
  localparam int unsigned CLIP_R_W    = 11;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_TUSER_W  = 3;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [CLIP_R_W-1:0] CLIP_RIGHT_RST = 11'd1024;

  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT = 1'd1;

  // run opcode boundaries
  localparam logic [7:0] OP_LIT_MAX     = 8'd127;
  localparam logic [7:0] OP_SIDE_MAX    = 8'd159;
  localparam logic [7:0] OP_SHADOW_MAX  = 8'd191;
  localparam logic [7:0] OP_CNT_LIT     = 8'd192;
  localparam logic [7:0] OP_CNT_LIT_PAD = 8'd193;
  localparam logic [7:0] OP_CNT_SIDE    = 8'd194;
  localparam logic [7:0] OP_CNT_SHADOW  = 8'd195;
  localparam logic [7:0] OP_SKIP        = 8'd196;
  localparam logic [7:0] OP_END_SCAN    = 8'd197;

  typedef enum logic [2:0] {
    FUNC_RECORD    = 3'd0,
    FUNC_SRC_BYTE  = 3'd1,
    FUNC_DST_BYTE  = 3'd2,
    FUNC_SIDE_WR   = 3'd3,
    FUNC_SHADOW_WR = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    RUN_IDLE   = 3'd0,
    RUN_LIT    = 3'd1,
    RUN_SIDE   = 3'd2,
    RUN_SHADOW = 3'd3,
    RUN_SKIP   = 3'd4
  } run_kind_e;

  typedef enum logic [1:0] {
    RES_PIXEL   = 2'd0,
    RES_END_ROW = 2'd1,
    RES_UNKNOWN = 2'd2
  } res_kind_e;

  typedef enum logic [1:0] {
    PIX_BYTE   = 2'd0,
    PIX_SIDE   = 2'd1,
    PIX_SHADOW = 2'd2
  } pix_sel_e;

  typedef struct packed {
    res_kind_e         kind;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [BYTE_W-1:0] raw;
    pix_sel_e          sel;
  } lookup_t;

endpackage

>>> hw/rtl/rle_sprite_scan_decoder.sv
// Channel   Dir  Handshake                    Payload (lowest bit first)
// s_axis    in   s_axis_tvalid/tready         tuser: func; tdata: op, run_length,
//                                             byte_value, table_index
// m_axis    out  m_axis_tvalid/tready         tuser: kind; tdata: column, row, pixel
// cfg       in   cfg_we_i (no wait)           cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle in, at most one result per transaction out.
// A result passes the lookup stage, where the table RAM is read, then the output register.
// Run state updates in the accept cycle; only the pixel value waits on the RAM.
// Input stalls only when both the lookup stage and the output register are full.
// Reset clears run state and the left clip and sets the right clip to 1024; the tables are not cleared.
module rle_sprite_scan_decoder #(
  parameter int unsigned MAX_WIDTH = rss_pkg::MAX_WIDTH,
  parameter int unsigned MAX_ROWS  = rss_pkg::MAX_ROWS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,

  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rss_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // op, run_length, byte_value, table_index
  input  logic [rss_pkg::IN_TUSER_W-1:0]     s_axis_tuser,  // func

  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rss_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // column, row, pixel, zero pad
  output logic [rss_pkg::OUT_TUSER_W-1:0]    m_axis_tuser,  // kind

  input  logic                               cfg_we_i,
  input  logic [rss_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned CW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = (CW > rss_pkg::CLIP_R_W) ? CW : rss_pkg::CLIP_R_W;
  localparam int unsigned SW   = ((CW > rss_pkg::BYTE_W) ? CW : rss_pkg::BYTE_W) + 1;
  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned RXW  = (RW > rss_pkg::ROW_W) ? RW : rss_pkg::ROW_W;
  localparam int unsigned BW   = rss_pkg::BYTE_W;
  localparam int unsigned TAW  = $clog2(rss_pkg::TABLE_DEPTH);

  // input unpacking
  rss_pkg::func_e  func;
  logic [BW-1:0]   op;
  logic [BW-1:0]   run_len;
  logic [BW-1:0]   byte_val;
  logic [BW-1:0]   tbl_idx;

  assign func     = rss_pkg::func_e'(s_axis_tuser);
  assign op       = s_axis_tdata[7:0];
  assign run_len  = s_axis_tdata[15:8];
  assign byte_val = s_axis_tdata[23:16];
  assign tbl_idx  = s_axis_tdata[31:24];

  // configuration
  logic [rss_pkg::CLIP_L_W-1:0] clip_left_q;
  logic [rss_pkg::CLIP_R_W-1:0] clip_right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_left_q  <= '0;
      clip_right_q <= rss_pkg::CLIP_RIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rss_pkg::CFG_CLIP_LEFT:  clip_left_q  <= cfg_wdata_i[rss_pkg::CLIP_L_W-1:0];
        rss_pkg::CFG_CLIP_RIGHT: clip_right_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // run state
  rss_pkg::run_kind_e        kind_q, kind_d;
  logic [CW-1:0]             col_q, col_d;
  logic [RW-1:0]             row_q, row_d;
  logic [rss_pkg::REM_W-1:0] rem_q, rem_d;
  logic                      pad_q, pad_d;
  logic                      cnt_q, cnt_d;

  // pipeline
  logic             s_acc;
  logic             out_free;
  logic             s1_v_q, s1_v_d;
  rss_pkg::lookup_t s1_q, s1_d;
  logic             out_v_q;
  rss_pkg::lookup_t out_q;
  logic [BW-1:0]    out_pix_q;

  logic [BW-1:0]    side_rdata;
  logic [BW-1:0]    shadow_rdata;

  // per-item working signals
  logic                 res_v;
  rss_pkg::res_kind_e   res_kind;
  rss_pkg::pix_sel_e    res_sel;
  logic                 put;
  rss_pkg::pix_sel_e    put_sel;
  logic                 adv_en;
  logic [BW-1:0]        adv_amt;
  logic [SW-1:0]        adv_sum;
  logic [CMPW-1:0]      col_x;
  logic [CMPW-1:0]      col_off;
  logic                 draw;
  logic [rss_pkg::REM_W-1:0] rem_dec;
  logic [RXW-1:0]       row_ext;

  assign out_free      = !out_v_q || m_axis_tready;
  assign s_axis_tready = !s1_v_q || out_free;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  assign col_x   = CMPW'(col_q);
  assign col_off = col_x - CMPW'(clip_left_q);
  assign draw    = (col_x >= CMPW'(clip_left_q)) && (col_x < CMPW'(clip_right_q))
                   && (col_x < CMPW'(MAX_WIDTH));
  assign rem_dec = (rem_q != '0) ? rem_q - 1'b1 : rem_q;
  assign adv_sum = SW'(col_q) + SW'(adv_amt);
  assign row_ext = RXW'(row_q);

  always_comb begin
    kind_d   = kind_q;
    row_d    = row_q;
    rem_d    = rem_q;
    pad_d    = pad_q;
    cnt_d    = cnt_q;
    res_v    = 1'b0;
    res_kind = rss_pkg::RES_PIXEL;
    res_sel  = rss_pkg::PIX_BYTE;
    put      = 1'b0;
    put_sel  = rss_pkg::PIX_BYTE;
    adv_en   = 1'b0;
    adv_amt  = '0;
    col_d    = col_q;

    if (s_acc) begin
      case (func)
        rss_pkg::FUNC_RECORD: begin
          pad_d  = 1'b0;
          cnt_d  = 1'b0;
          rem_d  = '0;
          kind_d = rss_pkg::RUN_IDLE;
          if (op <= rss_pkg::OP_LIT_MAX) begin
            pad_d  = op[0];
            rem_d  = rss_pkg::REM_W'(run_len);
            kind_d = (run_len == '0 && !op[0]) ? rss_pkg::RUN_IDLE : rss_pkg::RUN_LIT;
          end else if (op <= rss_pkg::OP_SIDE_MAX || op == rss_pkg::OP_CNT_SIDE) begin
            rem_d  = rss_pkg::REM_W'(run_len);
            cnt_d  = (op == rss_pkg::OP_CNT_SIDE);
            kind_d = (op != rss_pkg::OP_CNT_SIDE && run_len == '0) ?
                     rss_pkg::RUN_IDLE : rss_pkg::RUN_SIDE;
          end else if (op <= rss_pkg::OP_SHADOW_MAX || op == rss_pkg::OP_CNT_SHADOW) begin
            rem_d  = rss_pkg::REM_W'(run_len);
            cnt_d  = (op == rss_pkg::OP_CNT_SHADOW);
            kind_d = (op != rss_pkg::OP_CNT_SHADOW && run_len == '0) ?
                     rss_pkg::RUN_IDLE : rss_pkg::RUN_SHADOW;
          end else if (op == rss_pkg::OP_CNT_LIT || op == rss_pkg::OP_CNT_LIT_PAD) begin
            kind_d = rss_pkg::RUN_LIT;
            pad_d  = op[0];
            cnt_d  = 1'b1;
          end else if (op == rss_pkg::OP_SKIP) begin
            kind_d = rss_pkg::RUN_SKIP;
            cnt_d  = 1'b1;
          end else if (op == rss_pkg::OP_END_SCAN) begin
            res_v    = 1'b1;
            res_kind = rss_pkg::RES_END_ROW;
            row_d    = (row_q == RW'(MAX_ROWS - 1)) ? '0 : row_q + 1'b1;
            col_d    = '0;
          end else begin
            res_v    = 1'b1;
            res_kind = rss_pkg::RES_UNKNOWN;
          end
        end
        rss_pkg::FUNC_SRC_BYTE: begin
          if (kind_q != rss_pkg::RUN_IDLE) begin
            if (pad_q) begin
              pad_d = 1'b0;
              if (!cnt_q && rem_q == '0) begin
                kind_d = rss_pkg::RUN_IDLE;
              end
            end else if (cnt_q) begin
              cnt_d = 1'b0;
              if (kind_q == rss_pkg::RUN_SKIP) begin
                adv_en  = 1'b1;
                adv_amt = byte_val;
                kind_d  = rss_pkg::RUN_IDLE;
              end else begin
                rem_d = rss_pkg::REM_W'(byte_val) + 1'b1;
              end
            end else if (kind_q == rss_pkg::RUN_LIT) begin
              put     = 1'b1;
              put_sel = rss_pkg::PIX_BYTE;
            end else if (kind_q == rss_pkg::RUN_SIDE) begin
              put     = 1'b1;
              put_sel = rss_pkg::PIX_SIDE;
            end
          end
        end
        rss_pkg::FUNC_DST_BYTE: begin
          if (kind_q == rss_pkg::RUN_SHADOW && !cnt_q && rem_q != '0) begin
            put     = 1'b1;
            put_sel = rss_pkg::PIX_SHADOW;
          end
        end
        default: ;
      endcase

      if (put) begin
        res_v   = draw;
        res_sel = put_sel;
        adv_en  = 1'b1;
        adv_amt = BW'(1);
        rem_d   = rem_dec;
        if (rem_dec == '0) begin
          kind_d = rss_pkg::RUN_IDLE;
        end
      end

      if (adv_en) begin
        col_d = (adv_sum > SW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : adv_sum[CW-1:0];
      end
    end
  end

  always_comb begin
    s1_d.kind   = res_kind;
    s1_d.column = (res_kind == rss_pkg::RES_PIXEL) ? col_off[rss_pkg::COL_W-1:0] : '0;
    s1_d.row    = row_ext[rss_pkg::ROW_W-1:0];
    s1_d.raw    = byte_val;
    s1_d.sel    = res_sel;
    if (s_acc) begin
      s1_v_d = res_v;
    end else if (out_free) begin
      s1_v_d = 1'b0;
    end else begin
      s1_v_d = s1_v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= rss_pkg::RUN_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      rem_q   <= '0;
      pad_q   <= 1'b0;
      cnt_q   <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      kind_q <= kind_d;
      col_q  <= col_d;
      row_q  <= row_d;
      rem_q  <= rem_d;
      pad_q  <= pad_d;
      cnt_q  <= cnt_d;
      s1_v_q <= s1_v_d;
      if (out_free) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_q <= s1_d;
    end
    if (out_free && s1_v_q) begin
      out_q <= s1_q;
      case (s1_q.sel)
        rss_pkg::PIX_SIDE:   out_pix_q <= side_rdata;
        rss_pkg::PIX_SHADOW: out_pix_q <= shadow_rdata;
        default:             out_pix_q <= (s1_q.kind == rss_pkg::RES_PIXEL) ? s1_q.raw : '0;
      endcase
    end
  end

  // table RAMs: read data holds while the lookup stage is stalled
  rss_ram #(
    .WIDTH (BW),
    .DEPTH (rss_pkg::TABLE_DEPTH)
  ) u_side_ram (
    .clk_i   (clk_i),
    .we_i    (s_acc && func == rss_pkg::FUNC_SIDE_WR),
    .waddr_i (tbl_idx[TAW-1:0]),
    .wdata_i (byte_val),
    .re_i    (s_acc),
    .raddr_i (byte_val[TAW-1:0]),
    .rdata_o (side_rdata)
  );

  rss_ram #(
    .WIDTH (BW),
    .DEPTH (rss_pkg::TABLE_DEPTH)
  ) u_shadow_ram (
    .clk_i   (clk_i),
    .we_i    (s_acc && func == rss_pkg::FUNC_SHADOW_WR),
    .waddr_i (tbl_idx[TAW-1:0]),
    .wdata_i (byte_val),
    .re_i    (s_acc),
    .raddr_i (byte_val[TAW-1:0]),
    .rdata_o (shadow_rdata)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {4'b0000, out_pix_q, out_q.row, out_q.column};

  a_col_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= CW'(MAX_WIDTH))
    else $error("source column beyond saturation limit");

  a_row_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < MAX_ROWS)
    else $error("row counter beyond wrap point");

  a_pend_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pad_q || cnt_q) |-> kind_q != rss_pkg::RUN_IDLE)
    else $error("pad or count pending outside a run");

  a_end_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && func == rss_pkg::FUNC_RECORD && op == rss_pkg::OP_END_SCAN)
    |=> (s1_v_q && s1_q.kind == rss_pkg::RES_END_ROW && col_q == '0))
    else $error("end of scan did not yield an end-of-row result");

endmodule

>>> hw/rtl/rss_ram.sv
module rss_ram #(
  parameter int unsigned WIDTH = rss_pkg::BYTE_W,
  parameter int unsigned DEPTH = rss_pkg::TABLE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
